// ===== sv/hpt_pkg.sv =====
package hpt_pkg;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_POINT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DOT,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ===== sv/hpt_if.sv =====
interface hpt_in_if #(
    parameter int WORD_BITS = 32
) (
    input logic i_clk
);
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [1:0]                  row_index;
    logic [1:0]                  col_index;
    logic signed [WORD_BITS-1:0] entry_value;
    logic signed [WORD_BITS-1:0] point_x;
    logic signed [WORD_BITS-1:0] point_y;
    logic signed [WORD_BITS-1:0] point_z;

    modport source (output valid, kind, row_index, col_index, entry_value,
                    point_x, point_y, point_z, input ready);
    modport sink (input valid, kind, row_index, col_index, entry_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface hpt_out_if #(
    parameter int WORD_BITS = 32
) (
    input logic i_clk
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] out_x;
    logic signed [WORD_BITS-1:0] out_y;
    logic signed [WORD_BITS-1:0] out_z;
    logic                        zero_divisor;
    logic                        overflowed;

    modport source (output valid, out_x, out_y, out_z, zero_divisor, overflowed,
                    input ready);
    modport sink (input valid, out_x, out_y, out_z, zero_divisor, overflowed,
                  output ready);
endinterface

// ===== sv/homogeneous_point_transform_top.sv =====
// the back part works on one point at a time and pops the next one only after the last
// result has gone to the output register; the bit-serial divider runs once for each of
// the three coords
// load items give no result and wait until no point is queued or in flight
// reset: synchronous active-low; clears the matrix to zero, the queue and all valid flags
module homogeneous_point_transform_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpt_in_if.sink      i_in,
    hpt_out_if.source   o_out
);
    import hpt_pkg::*;

    logic                    w_push, w_pop, w_full, w_empty, w_busy;
    logic [3*WORD_BITS-1:0]  w_pdata, w_qdata;
    logic [16*WORD_BITS-1:0] w_matrix;

    hpt_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_in,
        .i_q_full(w_full), .i_q_empty(w_empty), .i_back_busy(w_busy),
        .o_q_push(w_push), .o_q_data(w_pdata), .o_matrix(w_matrix)
    );

    hpt_queue #(.DATA_BITS(3*WORD_BITS)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_pdata), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_data(w_qdata)
    );

    hpt_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_empty(w_empty), .i_q_data(w_qdata), .o_q_pop(w_pop),
        .o_busy(w_busy), .i_matrix(w_matrix), .o_out
    );
endmodule

// ===== sv/hpt_front.sv =====
module hpt_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hpt_in_if.sink                      i_in,
    input  logic                        i_q_full,
    input  logic                        i_q_empty,
    input  logic                        i_back_busy,
    output logic                        o_q_push,
    output logic [3*WORD_BITS-1:0]      o_q_data,
    output logic [16*WORD_BITS-1:0]     o_matrix
);
    import hpt_pkg::*;

    logic [WORD_BITS-1:0] r_mat [16];
    logic                 w_load;

    // a load waits until no point is queued or in the back part
    assign i_in.ready = (t_kind'(i_in.kind) == KIND_POINT) ? !i_q_full
                                                           : (i_q_empty && !i_back_busy);
    assign w_load     = i_in.valid && i_in.ready && (t_kind'(i_in.kind) == KIND_LOAD);
    assign o_q_push   = i_in.valid && i_in.ready && (t_kind'(i_in.kind) == KIND_POINT);
    assign o_q_data   = {i_in.point_z, i_in.point_y, i_in.point_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_mat[k] <= '0;
        end else if (w_load) begin
            r_mat[{i_in.row_index, i_in.col_index}] <= i_in.entry_value;
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) o_matrix[k*WORD_BITS +: WORD_BITS] = r_mat[k];
    end
endmodule

// ===== sv/hpt_queue.sv =====
module hpt_queue #(
    parameter int DATA_BITS = 96
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output logic [DATA_BITS-1:0] o_data
);
    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push when full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue pop when empty");
`endif
endmodule

// ===== sv/hpt_back.sv =====
module hpt_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  logic [3*WORD_BITS-1:0]  i_q_data,
    output logic                    o_q_pop,
    output logic                    o_busy,
    input  logic [16*WORD_BITS-1:0] i_matrix,
    hpt_out_if.source               o_out
);
    import hpt_pkg::*;

    localparam int PB  = 2 * WORD_BITS;
    localparam int SB  = PB + 3;
    localparam int DB  = SB - FRAC_BITS;
    localparam int NB  = DB + FRAC_BITS;
    localparam int CB  = $clog2(NB + 1);
    localparam logic [NB-1:0] MAXP = NB'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic [NB-1:0] MAXN = NB'({1'b1, {(WORD_BITS-1){1'b0}}});

    t_back_state r_state, n_state;
    logic [1:0]  r_row;
    logic [CB-1:0] r_cnt;
    logic [1:0]  r_co;

    logic signed [WORD_BITS-1:0] w_px, w_py, w_pz;
    logic signed [WORD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [WORD_BITS-1:0] w_m0, w_m1, w_m2, w_m3;
    logic signed [PB-1:0] r_p0, r_p1, r_p2;
    logic signed [WORD_BITS-1:0] r_m3;
    logic                        r_pv;
    logic [1:0]                  r_prow;
    logic signed [SB-1:0]        w_sum;
    logic signed [DB-1:0]        w_dot;
    logic signed [DB-1:0]        r_d [4];
    logic                        r_dvalid;

    logic [NB-1:0] r_rem, r_quo, r_num, r_den;
    logic [NB:0]   w_trial;
    logic          w_neg;
    logic [NB-1:0] w_lim;
    logic signed [WORD_BITS-1:0] r_res [3];
    logic          r_zero, r_ovf;
    logic          w_q_ok, w_out_free;
    logic          w_sat;
    logic signed [WORD_BITS-1:0] w_val;

    assign w_px = i_q_data[0 +: WORD_BITS];
    assign w_py = i_q_data[WORD_BITS +: WORD_BITS];
    assign w_pz = i_q_data[2*WORD_BITS +: WORD_BITS];
    assign w_m0 = i_matrix[{r_row, 2'd0}*WORD_BITS +: WORD_BITS];
    assign w_m1 = i_matrix[{r_row, 2'd1}*WORD_BITS +: WORD_BITS];
    assign w_m2 = i_matrix[{r_row, 2'd2}*WORD_BITS +: WORD_BITS];
    assign w_m3 = i_matrix[{r_row, 2'd3}*WORD_BITS +: WORD_BITS];

    assign w_sum = SB'(r_p0) + SB'(r_p1) + SB'(r_p2)
                 + (SB'(r_m3) <<< FRAC_BITS);
    assign w_dot = DB'(w_sum >>> FRAC_BITS);

    assign w_out_free = !o_out.valid || o_out.ready;
    assign w_q_ok = (r_state == BK_IDLE) && !i_q_empty;
    assign o_q_pop = w_q_ok;
    assign o_busy = r_state != BK_IDLE;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_DOT;
            BK_DOT:  if (r_dvalid) n_state = BK_DIV;
            BK_DIV:  if (r_cnt == CB'(0) && r_co == 2'd2) n_state = BK_OUT;
            BK_OUT:  if (w_out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // divide step: restoring, one quotient bit a cycle
    assign w_trial = {r_rem, r_num[NB-1]} - {1'b0, r_den};
    assign w_neg = r_d[r_co][DB-1] ^ r_d[3][DB-1];
    assign w_lim = w_neg ? MAXN : MAXP;
    always_comb begin
        w_sat = 1'b0;
        w_val = '0;
        if (r_d[3] == '0) begin
            w_sat = r_d[r_co] != '0;
            w_val = r_d[r_co] == '0 ? '0 :
                    (r_d[r_co][DB-1] ? WORD_BITS'(MAXN) : WORD_BITS'(MAXP));
        end else if (r_quo > w_lim) begin
            w_sat = 1'b1;
            w_val = w_neg ? WORD_BITS'(MAXN) : WORD_BITS'(MAXP);
        end else begin
            w_val = w_neg ? WORD_BITS'(-r_quo) : WORD_BITS'(r_quo);
        end
    end

    function automatic logic [NB-1:0] f_abs(input logic signed [DB-1:0] v);
        logic signed [NB-1:0] e;
        e = NB'(v);
        return e[NB-1] ? NB'(-e) : NB'(e);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_q_ok) begin
            r_px <= w_px;
            r_py <= w_py;
            r_pz <= w_pz;
        end
        r_p0 <= PB'(w_m0) * PB'(r_px);
        r_p1 <= PB'(w_m1) * PB'(r_py);
        r_p2 <= PB'(w_m2) * PB'(r_pz);
        r_m3 <= w_m3;
        r_prow <= r_row;
        if (r_pv) r_d[r_prow] <= w_dot;
        if (r_state == BK_DOT && r_dvalid) begin
            r_num <= f_abs(r_d[0]) << FRAC_BITS;
            r_den <= f_abs(r_d[3]);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_state == BK_DIV) begin
            if (r_cnt != CB'(0)) begin
                r_num <= r_num << 1;
                r_rem <= w_trial[NB] ? NB'({r_rem, r_num[NB-1]}) : NB'(w_trial);
                r_quo <= {r_quo[NB-2:0], !w_trial[NB]};
            end else begin
                r_res[r_co] <= w_val;
                r_num <= f_abs(r_d[r_co + 2'd1]) << FRAC_BITS;
                r_rem <= '0;
                r_quo <= '0;
            end
        end
        if (r_state == BK_DOT && r_dvalid) r_ovf <= 1'b0;
        else if (r_state == BK_DIV && r_cnt == CB'(0)) r_ovf <= r_ovf | w_sat;
        if (r_state == BK_DOT && r_dvalid) r_zero <= r_d[3] == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_row    <= 2'd0;
            r_pv     <= 1'b0;
            r_dvalid <= 1'b0;
            r_cnt    <= '0;
            r_co     <= 2'd0;
            o_out.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv <= (r_state == BK_DOT) && !r_dvalid;
            if (w_q_ok) r_row <= 2'd0;
            else if (r_state == BK_DOT && r_row != 2'd3) r_row <= r_row + 2'd1;
            if (w_q_ok) r_dvalid <= 1'b0;
            else if (r_state == BK_DOT && r_pv && r_prow == 2'd3) r_dvalid <= 1'b1;
            if (r_state == BK_DOT && r_dvalid) begin
                r_cnt <= CB'(NB);
                r_co  <= 2'd0;
            end else if (r_state == BK_DIV) begin
                if (r_cnt != CB'(0)) r_cnt <= r_cnt - CB'(1);
                else if (r_co != 2'd2) begin
                    r_co  <= r_co + 2'd1;
                    r_cnt <= CB'(NB);
                end
            end
            if (r_state == BK_OUT && w_out_free) o_out.valid <= 1'b1;
            else if (o_out.valid && o_out.ready) o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_OUT && w_out_free) begin
            o_out.out_x <= r_res[0];
            o_out.out_y <= r_res[1];
            o_out.out_z <= r_res[2];
            o_out.zero_divisor <= r_zero;
            o_out.overflowed <= r_ovf;
        end
    end

`ifndef SYNTH
    a_div_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> r_dvalid) else $error("divide before dots");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == BK_IDLE)) else $error("pop while busy");
    a_co_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_co != 2'd3)) else $error("coord index range");
`endif
endmodule
